/* rtl/sbi_pkg.sv */
package sbi_pkg;

   localparam int CodeDepthDefault   = 4096;
   localparam int StackDepthDefault  = 256;
   localparam int LocalsDepthDefault = 256;

   localparam int CsrWidth = 13;

   // instructions a run may execute before it is dropped
   localparam int WatchdogSteps = 4194304;

   localparam logic [1:0] MODE_CODE  = 2'd0;
   localparam logic [1:0] MODE_LOCAL = 2'd1;
   localparam logic [1:0] MODE_RUN   = 2'd2;

   localparam logic [1:0] CSR_CODE_LENGTH  = 2'd0;
   localparam logic [1:0] CSR_STACK_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_LOCALS_LIMIT = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_ARITH   = 2'd2;

   localparam logic [7:0] OP_PUSH     = 8'd0;
   localparam logic [7:0] OP_LOAD     = 8'd1;
   localparam logic [7:0] OP_STORE    = 8'd2;
   localparam logic [7:0] OP_ADD      = 8'd3;
   localparam logic [7:0] OP_SUB      = 8'd4;
   localparam logic [7:0] OP_MUL      = 8'd5;
   localparam logic [7:0] OP_AND      = 8'd6;
   localparam logic [7:0] OP_OR       = 8'd7;
   localparam logic [7:0] OP_XOR      = 8'd8;
   localparam logic [7:0] OP_SHL      = 8'd9;
   localparam logic [7:0] OP_SAR      = 8'd10;
   localparam logic [7:0] OP_SHR      = 8'd11;
   localparam logic [7:0] OP_DIV      = 8'd12;
   localparam logic [7:0] OP_REM      = 8'd13;
   localparam logic [7:0] OP_NEG      = 8'd14;
   localparam logic [7:0] OP_IF_EQ    = 8'd15;
   localparam logic [7:0] OP_IF_LE    = 8'd20;
   localparam logic [7:0] OP_IFCMP_EQ = 8'd21;
   localparam logic [7:0] OP_IFCMP_LE = 8'd26;
   localparam logic [7:0] OP_GOTO     = 8'd27;
   localparam logic [7:0] OP_RETURN   = 8'd28;

   localparam logic [2:0] CMP_EQ = 3'd0;
   localparam logic [2:0] CMP_NE = 3'd1;
   localparam logic [2:0] CMP_LT = 3'd2;
   localparam logic [2:0] CMP_GE = 3'd3;
   localparam logic [2:0] CMP_GT = 3'd4;

   typedef struct packed {
      logic       code_wr;
      logic       loc_wr;
      logic       run_start;
      logic       op_load;
      logic       pc_inc;
      logic       pc_jump;
      logic       acc_shift;
      logic       r_load;
      logic       rd_far;
      logic       push;
      logic       replace;
      logic       neg;
      logic       store;
      logic       pop1;
      logic       pop2;
      logic       div_start;
      logic       emit;
      logic [1:0] emit_status;
   } cmd_type;

   typedef struct packed {
      logic [7:0] op;
      logic       pc_lt_len;
      logic       opnd_fits;
      logic       sp_lt_limit;
      logic       sp_ge1;
      logic       sp_ge2;
      logic       idx_ok;
      logic       tgt_ok;
      logic       taken;
      logic       r_zero;
      logic       div_done;
   } sts_type;

   function automatic logic is_branch1(input logic [7:0] op);
      return op >= OP_IF_EQ && op <= OP_IF_LE;
   endfunction

   function automatic logic is_branch2(input logic [7:0] op);
      return op >= OP_IFCMP_EQ && op <= OP_IFCMP_LE;
   endfunction

   function automatic logic is_binary(input logic [7:0] op);
      return op >= OP_ADD && op <= OP_REM;
   endfunction

   function automatic logic is_divide(input logic [7:0] op);
      return op == OP_DIV || op == OP_REM;
   endfunction

   function automatic logic has_operand(input logic [7:0] op);
      return op == OP_PUSH || op == OP_LOAD || op == OP_STORE || op == OP_GOTO
             || is_branch1(op) || is_branch2(op);
   endfunction

   // u16 operands for local access, u32 for everything else
   function automatic logic [2:0] opnd_bytes(input logic [7:0] op);
      return (op == OP_LOAD || op == OP_STORE) ? 3'd2 : 3'd4;
   endfunction

endpackage

/* rtl/sbi_div.sv */
module sbi_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        negq_ff, negq_in;
   logic        negr_ff, negr_in;
   logic [31:0] shifted;
   logic [32:0] diff;

   always_comb begin
      shifted = {rem_ff[30:0], quo_ff[31]};
      diff    = {1'b0, shifted} - {1'b0, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      negq_in = negq_ff;
      negr_in = negr_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[31] ? 32'd0 - dividend : dividend;
         dvs_in  = divisor[31] ? 32'd0 - divisor : divisor;
         negq_in = dividend[31] ^ divisor[31];
         negr_in = dividend[31];
      end else if (run_ff) begin
         // restoring step, one quotient bit a cycle
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
   end

   assign done      = done_ff;
   assign quotient  = negq_ff ? 32'd0 - quo_ff : quo_ff;
   assign remainder = negr_ff ? 32'd0 - rem_ff : rem_ff;

endmodule

/* rtl/sbi_dp.sv */
module sbi_dp #(
   parameter int CODE_DEPTH   = sbi_pkg::CodeDepthDefault,
   parameter int STACK_DEPTH  = sbi_pkg::StackDepthDefault,
   parameter int LOCALS_DEPTH = sbi_pkg::LocalsDepthDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [11:0]                  req_slot,
   input  logic [7:0]                   req_code_byte,
   input  logic [31:0]                  req_local_value,
   input  logic                         csr_write_enable,
   input  logic [1:0]                   csr_index,
   input  logic [sbi_pkg::CsrWidth-1:0] csr_write_data,
   input  sbi_pkg::cmd_type             cmd,
   output sbi_pkg::sts_type             sts,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [31:0]                  rsp_return_value
);

   localparam int CAW = $clog2(CODE_DEPTH);
   localparam int PCW = $clog2(CODE_DEPTH + 1);
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int LAW = (LOCALS_DEPTH > 1) ? $clog2(LOCALS_DEPTH) : 1;

   logic [7:0]  code_mem  [CODE_DEPTH];
   logic [31:0] stack_mem [STACK_DEPTH];
   logic [31:0] local_mem [LOCALS_DEPTH];

   logic [12:0]    code_length_ff;
   logic [8:0]     stack_limit_ff;
   logic [8:0]     locals_limit_ff;
   logic [PCW-1:0] pc_ff, pc_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [7:0]     op_ff;
   logic [31:0]    acc_ff;
   logic [31:0]    r_ff;
   logic [7:0]     code_rd_ff;
   logic [31:0]    stack_rd_ff;
   logic [31:0]    local_rd_ff;
   logic           rsp_valid_ff;
   logic [1:0]     rsp_status_ff;
   logic [31:0]    rsp_value_ff;

   logic [31:0]    len_c, smax_c, lmax_c, v, l, alu, wr_val, neg_val;
   logic [SPW-1:0] sp_m1, sp_m2;
   logic [SAW-1:0] stk_rd_addr, stk_wr_addr;
   logic           stk_wr;
   logic [LAW-1:0] loc_addr;
   logic           loc_we;
   logic [31:0]    loc_data;
   logic [4:0]     shamt;
   logic [2:0]     cond;
   logic signed [31:0] cmp_l, cmp_r;
   logic           cmp;
   logic           div_done;
   logic [31:0]    div_q, div_r;

   sbi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (stack_rd_ff),
      .divisor   (r_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      len_c  = (32'(code_length_ff) > 32'(CODE_DEPTH)) ? 32'(CODE_DEPTH)
                                                        : 32'(code_length_ff);
      smax_c = (32'(stack_limit_ff) > 32'(STACK_DEPTH)) ? 32'(STACK_DEPTH)
                                                         : 32'(stack_limit_ff);
      lmax_c = (32'(locals_limit_ff) > 32'(LOCALS_DEPTH)) ? 32'(LOCALS_DEPTH)
                                                           : 32'(locals_limit_ff);
      // u16 operands end up in the top half after the byte shifts
      v = (op_ff == sbi_pkg::OP_LOAD || op_ff == sbi_pkg::OP_STORE)
          ? {16'h0, acc_ff[31:16]} : acc_ff;
      l     = stack_rd_ff;
      sp_m1 = sp_ff - SPW'(1);
      sp_m2 = sp_ff - SPW'(2);
      shamt = r_ff[4:0];
      case (op_ff)
         sbi_pkg::OP_ADD: alu = l + r_ff;
         sbi_pkg::OP_SUB: alu = l - r_ff;
         sbi_pkg::OP_MUL: alu = l * r_ff;
         sbi_pkg::OP_AND: alu = l & r_ff;
         sbi_pkg::OP_OR:  alu = l | r_ff;
         sbi_pkg::OP_XOR: alu = l ^ r_ff;
         sbi_pkg::OP_SHL: alu = l << shamt;
         sbi_pkg::OP_SAR: alu = $unsigned($signed(l) >>> shamt);
         sbi_pkg::OP_SHR: alu = l >> shamt;
         sbi_pkg::OP_DIV: alu = div_q;
         default:         alu = div_r;
      endcase
      neg_val = 32'd0 - r_ff;
      if (sbi_pkg::is_branch1(op_ff)) begin
         cond  = 3'(op_ff - sbi_pkg::OP_IF_EQ);
         cmp_l = $signed(r_ff);
         cmp_r = '0;
      end else begin
         cond  = 3'(op_ff - sbi_pkg::OP_IFCMP_EQ);
         cmp_l = $signed(l);
         cmp_r = $signed(r_ff);
      end
      case (cond)
         sbi_pkg::CMP_EQ: cmp = cmp_l == cmp_r;
         sbi_pkg::CMP_NE: cmp = cmp_l != cmp_r;
         sbi_pkg::CMP_LT: cmp = cmp_l < cmp_r;
         sbi_pkg::CMP_GE: cmp = cmp_l >= cmp_r;
         sbi_pkg::CMP_GT: cmp = cmp_l > cmp_r;
         default:         cmp = cmp_l <= cmp_r;
      endcase

      stk_rd_addr = cmd.rd_far ? sp_m2[SAW-1:0] : sp_m1[SAW-1:0];
      stk_wr      = cmd.push || cmd.replace || cmd.neg;
      if (cmd.push) begin
         stk_wr_addr = sp_ff[SAW-1:0];
         wr_val      = (op_ff == sbi_pkg::OP_LOAD) ? local_rd_ff : v;
      end else if (cmd.neg) begin
         stk_wr_addr = sp_m1[SAW-1:0];
         wr_val      = neg_val;
      end else begin
         stk_wr_addr = sp_m2[SAW-1:0];
         wr_val      = alu;
      end

      if (cmd.loc_wr) begin
         loc_addr = LAW'(req_slot);
         loc_we   = 32'(req_slot) < 32'(LOCALS_DEPTH);
         loc_data = req_local_value;
      end else begin
         loc_addr = v[LAW-1:0];
         loc_we   = cmd.store;
         loc_data = r_ff;
      end

      pc_in = pc_ff;
      if (cmd.run_start) pc_in = '0;
      else if (cmd.pc_jump) pc_in = v[PCW-1:0];
      else if (cmd.pc_inc) pc_in = pc_ff + PCW'(1);

      sp_in = sp_ff;
      if (cmd.run_start) sp_in = '0;
      else if (cmd.push) sp_in = sp_ff + SPW'(1);
      else if (cmd.replace || cmd.store || cmd.pop1) sp_in = sp_m1;
      else if (cmd.pop2) sp_in = sp_m2;
   end

   always_ff @(posedge clock) begin
      if (cmd.code_wr && 32'(req_slot) < 32'(CODE_DEPTH)) begin
         code_mem[CAW'(req_slot)] <= req_code_byte;
      end
      code_rd_ff <= code_mem[pc_ff[CAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (stk_wr) begin
         stack_mem[stk_wr_addr] <= wr_val;
      end
      stack_rd_ff <= stack_mem[stk_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (loc_we) begin
         local_mem[loc_addr] <= loc_data;
      end
      local_rd_ff <= local_mem[v[LAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_length_ff  <= '0;
         stack_limit_ff  <= '0;
         locals_limit_ff <= '0;
         pc_ff           <= '0;
         sp_ff           <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               sbi_pkg::CSR_CODE_LENGTH:  code_length_ff  <= csr_write_data;
               sbi_pkg::CSR_STACK_LIMIT:  stack_limit_ff  <= csr_write_data[8:0];
               sbi_pkg::CSR_LOCALS_LIMIT: locals_limit_ff <= csr_write_data[8:0];
               default: ;
            endcase
         end
         pc_ff        <= pc_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.op_load) op_ff <= code_rd_ff;
      if (cmd.acc_shift) acc_ff <= {code_rd_ff, acc_ff[31:8]};
      if (cmd.r_load) r_ff <= stack_rd_ff;
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_value_ff  <= (cmd.emit_status == sbi_pkg::ST_OK) ? r_ff : 32'd0;
      end
   end

   always_comb begin
      sts.op          = op_ff;
      sts.pc_lt_len   = 32'(pc_ff) < len_c;
      sts.opnd_fits   = (len_c - 32'(pc_ff)) >= 32'(sbi_pkg::opnd_bytes(op_ff));
      sts.sp_lt_limit = 32'(sp_ff) < smax_c;
      sts.sp_ge1      = sp_ff != '0;
      sts.sp_ge2      = 32'(sp_ff) >= 32'd2;
      sts.idx_ok      = v < lmax_c;
      sts.tgt_ok      = v < len_c;
      sts.taken       = cmp;
      sts.r_zero      = r_ff == 32'd0;
      sts.div_done    = div_done;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_return_value = rsp_value_ff;

endmodule

/* rtl/sbi_ctrl.sv */
module sbi_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_mode,
   output logic             busy,
   output sbi_pkg::cmd_type cmd,
   input  sbi_pkg::sts_type sts
);

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_FETCH    = 11'b000_0000_0010,
      S_DECODE   = 11'b000_0000_0100,
      S_DISPATCH = 11'b000_0000_1000,
      S_OPND     = 11'b000_0001_0000,
      S_CHK      = 11'b000_0010_0000,
      S_RD1      = 11'b000_0100_0000,
      S_RD2      = 11'b000_1000_0000,
      S_EXEC     = 11'b001_0000_0000,
      S_DIV      = 11'b010_0000_0000,
      S_LDW      = 11'b100_0000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [22:0] steps_ff, steps_in;
   logic        last;
   logic [7:0]  op;

   assign op   = sts.op;
   assign last = cnt_ff == 2'(sbi_pkg::opnd_bytes(op) - 3'd1);
   assign busy = state_ff != S_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      steps_in = steps_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.code_wr = req_mode == sbi_pkg::MODE_CODE;
               cmd.loc_wr  = req_mode == sbi_pkg::MODE_LOCAL;
               if (req_mode == sbi_pkg::MODE_RUN) begin
                  cmd.run_start = 1'b1;
                  steps_in      = '0;
                  state_in      = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            if (sts.pc_lt_len) begin
               if (steps_ff == 23'(sbi_pkg::WatchdogSteps)) begin
                  // runaway program: drop the run without a result
                  state_in = S_IDLE;
               end else begin
                  cmd.pc_inc = 1'b1;
                  steps_in   = steps_ff + 23'd1;
                  state_in   = S_DECODE;
               end
            end else begin
               cmd.emit        = 1'b1;
               cmd.emit_status = sbi_pkg::ST_INVALID;
               state_in        = S_IDLE;
            end
         end
         S_DECODE: begin
            cmd.op_load = 1'b1;
            state_in    = S_DISPATCH;
         end
         S_DISPATCH: begin
            cnt_in = '0;
            if (sbi_pkg::has_operand(op) && sts.opnd_fits) begin
               cmd.pc_inc = 1'b1;
               state_in   = S_OPND;
            end else if ((sbi_pkg::is_binary(op) && sts.sp_ge2)
                         || ((op == sbi_pkg::OP_NEG || op == sbi_pkg::OP_RETURN)
                             && sts.sp_ge1)) begin
               state_in = S_RD1;
            end else begin
               cmd.emit        = 1'b1;
               cmd.emit_status = sbi_pkg::ST_INVALID;
               state_in        = S_IDLE;
            end
         end
         S_OPND: begin
            cmd.acc_shift = 1'b1;
            if (last) begin
               state_in = S_CHK;
            end else begin
               cmd.pc_inc = 1'b1;
               cnt_in     = cnt_ff + 2'd1;
            end
         end
         S_CHK: begin
            cmd.emit        = 1'b1;
            cmd.emit_status = sbi_pkg::ST_INVALID;
            state_in        = S_IDLE;
            if (op == sbi_pkg::OP_PUSH && sts.sp_lt_limit) begin
               cmd.emit = 1'b0;
               cmd.push = 1'b1;
               state_in = S_FETCH;
            end else if (op == sbi_pkg::OP_LOAD && sts.idx_ok && sts.sp_lt_limit) begin
               cmd.emit = 1'b0;
               state_in = S_LDW;
            end else if ((op == sbi_pkg::OP_STORE && sts.idx_ok && sts.sp_ge1)
                         || (sbi_pkg::is_branch1(op) && sts.sp_ge1)
                         || (sbi_pkg::is_branch2(op) && sts.sp_ge2)) begin
               cmd.emit = 1'b0;
               state_in = S_RD1;
            end else if (op == sbi_pkg::OP_GOTO && sts.tgt_ok) begin
               cmd.emit    = 1'b0;
               cmd.pc_jump = 1'b1;
               state_in    = S_FETCH;
            end
         end
         S_LDW: begin
            cmd.push = 1'b1;
            state_in = S_FETCH;
         end
         S_RD1: begin
            state_in = S_RD2;
         end
         S_RD2: begin
            cmd.r_load = 1'b1;
            cmd.rd_far = 1'b1;
            state_in   = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_FETCH;
            if (sbi_pkg::is_divide(op)) begin
               if (sts.r_zero) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = sbi_pkg::ST_ARITH;
                  state_in        = S_IDLE;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end else if (sbi_pkg::is_binary(op)) begin
               cmd.replace = 1'b1;
            end else if (op == sbi_pkg::OP_NEG) begin
               cmd.neg = 1'b1;
            end else if (op == sbi_pkg::OP_STORE) begin
               cmd.store = 1'b1;
            end else if (op == sbi_pkg::OP_RETURN) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = sbi_pkg::ST_OK;
               state_in        = S_IDLE;
            end else begin
               // conditional branches: operands already in hand, pop them
               cmd.pop1 = sbi_pkg::is_branch1(op);
               cmd.pop2 = sbi_pkg::is_branch2(op);
               if (sts.taken) begin
                  if (sts.tgt_ok) begin
                     cmd.pc_jump = 1'b1;
                  end else begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = sbi_pkg::ST_INVALID;
                     state_in        = S_IDLE;
                  end
               end
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.replace = 1'b1;
               state_in    = S_FETCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         steps_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         steps_ff <= steps_in;
      end
   end

   a_run_fetches: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start && req_mode == sbi_pkg::MODE_RUN) |=> state_ff == S_FETCH)
      else $error("run word did not start fetching");

   a_emit_ends_run: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == S_IDLE)
      else $error("result issued but run continues");

   a_pc_single_update: assert property (@(posedge clock) disable iff (reset)
      !(cmd.pc_jump && cmd.pc_inc))
      else $error("pc jump and increment together");

   a_div_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && !sts.div_done) |=> state_ff == S_DIV)
      else $error("left divide wait early");

endmodule

/* rtl/stack_bytecode_interpreter.sv */
// channel  ports                                      handshake
// req      req_mode req_slot req_code_byte            start & !busy
//          req_local_value
// rsp      rsp_status rsp_return_value                rsp_valid, one cycle
// csr      csr_index csr_write_data                   csr_write_enable
//
// code and local load words leave busy low, so they can be issued back to back.
// a run word keeps busy high while it interprets: per instruction fetch, decode and
// dispatch, plus the operand bytes and a check for those with an operand, a push state
// for a loaded local, stack reads where the stack is used, and for div and rem a wait on
// the shared bit-serial divider; a run past 4194304 instructions ends with no result.
// reset clears the controller and config registers; stores are undefined until written.
// rsp_valid is a one-cycle strobe; the receiver cannot stall it.
module stack_bytecode_interpreter #(
   parameter int CODE_DEPTH   = sbi_pkg::CodeDepthDefault,
   parameter int STACK_DEPTH  = sbi_pkg::StackDepthDefault,
   parameter int LOCALS_DEPTH = sbi_pkg::LocalsDepthDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_mode,
   input  logic [11:0]                  req_slot,
   input  logic [7:0]                   req_code_byte,
   input  logic signed [31:0]           req_local_value,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic signed [31:0]           rsp_return_value,
   input  logic                         csr_write_enable,
   input  logic [1:0]                   csr_index,
   input  logic [sbi_pkg::CsrWidth-1:0] csr_write_data
);

   sbi_pkg::cmd_type cmd;
   sbi_pkg::sts_type sts;
   logic [31:0]      ret_value;

   sbi_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .busy     (busy),
      .cmd      (cmd),
      .sts      (sts)
   );

   sbi_dp #(
      .CODE_DEPTH   (CODE_DEPTH),
      .STACK_DEPTH  (STACK_DEPTH),
      .LOCALS_DEPTH (LOCALS_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_slot         (req_slot),
      .req_code_byte    (req_code_byte),
      .req_local_value  ($unsigned(req_local_value)),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_return_value (ret_value)
   );

   assign rsp_return_value = $signed(ret_value);

endmodule
